>>> rtl/core/dmc_pkg.sv
// shared constants and types for the direct-mapped cache tag lookup
package dmc_pkg;

   // address layout
   localparam int ADDR_BITS   = 32;
   localparam int OFFSET_BITS = 5;
   localparam int LINE_BITS   = 7;
   localparam int NUM_LINES   = 1 << LINE_BITS;
   localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - LINE_BITS;
   localparam int BLOCK_BITS  = ADDR_BITS - OFFSET_BITS;

   // statistics counters
   localparam int COUNT_BITS = 32;

   // counter update request from the lookup stage
   typedef struct packed {
      logic update;
      logic miss;
   } cnt_ctl_type;

endpackage

>>> rtl/core/direct_mapped_cache_tag_lookup.sv
// top level of the direct-mapped cache tag lookup
//
// Each transfer on the req_ channel carries one 32-bit byte address. The
// block splits it into offset, block number, line index and tag, looks the
// line up in a 128-entry tag memory and returns one transfer on the rsp_
// channel with the hit/miss verdict, replacement flag, evicted tag and the
// running saturating hit and miss counts including this access.
// Every access writes its tag into the line and marks the line valid.
// The address is accepted with the registered memory read into the lookup
// stage, and the compare, write-back and output register load happen when
// that stage fires. One address is accepted per cycle while req_stall is
// low; a reference to the same line as the one just ahead of it takes the
// new tag from a forwarding register instead of the memory read.
// Reset clears the valid bits and counters at once; the tag memory needs no
// clearing, since a tag is used only for a valid line.
// When rsp_stall is high with a result waiting, the lookup stage holds its
// address and req_stall rises until the output register frees up.
module direct_mapped_cache_tag_lookup (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dmc_pkg::ADDR_BITS-1:0]    req_address,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dmc_pkg::OFFSET_BITS-1:0]  rsp_byte_offset,
   output logic [dmc_pkg::BLOCK_BITS-1:0]   rsp_block_number,
   output logic [dmc_pkg::LINE_BITS-1:0]    rsp_line_index,
   output logic [dmc_pkg::TAG_BITS-1:0]     rsp_tag_value,
   output logic                             rsp_is_miss,
   output logic                             rsp_is_replacement,
   output logic [dmc_pkg::TAG_BITS-1:0]     rsp_evicted_tag,
   output logic [dmc_pkg::COUNT_BITS-1:0]   rsp_hits_so_far,
   output logic [dmc_pkg::COUNT_BITS-1:0]   rsp_misses_so_far
);

   // lookup stage
   logic                            s1_valid_ff;
   logic [dmc_pkg::ADDR_BITS-1:0]   s1_addr_ff;
   logic                            fwd_valid_ff;
   logic                            fwd_valid_in;
   logic [dmc_pkg::TAG_BITS-1:0]    fwd_tag_ff;
   logic [dmc_pkg::NUM_LINES-1:0]   line_valid_ff;

   // output register
   logic                            out_valid_ff;
   logic [dmc_pkg::ADDR_BITS-1:0]   out_addr_ff;
   logic                            out_miss_ff;
   logic                            out_repl_ff;
   logic [dmc_pkg::TAG_BITS-1:0]    out_evict_ff;
   logic [dmc_pkg::COUNT_BITS-1:0]  out_hits_ff;
   logic [dmc_pkg::COUNT_BITS-1:0]  out_misses_ff;

   logic                            req_accept;
   logic                            s1_fire;
   logic [dmc_pkg::LINE_BITS-1:0]   req_index;
   logic [dmc_pkg::LINE_BITS-1:0]   s1_index;
   logic [dmc_pkg::TAG_BITS-1:0]    s1_tag;
   logic [dmc_pkg::TAG_BITS-1:0]    ram_tag;
   logic [dmc_pkg::TAG_BITS-1:0]    old_tag;
   logic                            was_valid;
   logic                            s1_miss;
   logic                            s1_repl;
   dmc_pkg::cnt_ctl_type            cnt_ctl;
   logic [dmc_pkg::COUNT_BITS-1:0]  hit_in;
   logic [dmc_pkg::COUNT_BITS-1:0]  miss_in;

   // handshake
   assign s1_fire    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;

   // address fields
   assign req_index = req_address[dmc_pkg::OFFSET_BITS +: dmc_pkg::LINE_BITS];
   assign s1_index  = s1_addr_ff[dmc_pkg::OFFSET_BITS +: dmc_pkg::LINE_BITS];
   assign s1_tag    = s1_addr_ff[dmc_pkg::ADDR_BITS-1 -: dmc_pkg::TAG_BITS];

   dmc_tag_ram u_tag_ram (
      .clock    (clock),
      .rd_en    (req_accept),
      .rd_index (req_index),
      .rd_tag   (ram_tag),
      .wr_en    (s1_fire),
      .wr_index (s1_index),
      .wr_tag   (s1_tag)
   );

   // forward the tag being written when the next reference hits the same line
   assign fwd_valid_in = s1_fire && (req_index == s1_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff  <= 1'b1;
         fwd_valid_ff <= fwd_valid_in;
      end else if (s1_fire) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff <= req_address;
         fwd_tag_ff <= s1_tag;
      end
   end

   // compare against the stored line
   assign old_tag   = fwd_valid_ff ? fwd_tag_ff : ram_tag;
   assign was_valid = line_valid_ff[s1_index];
   assign s1_miss   = !was_valid || (old_tag != s1_tag);
   assign s1_repl   = s1_miss && was_valid;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
      end else if (s1_fire) begin
         line_valid_ff[s1_index] <= 1'b1;
      end
   end

   // statistics
   assign cnt_ctl.update = s1_fire;
   assign cnt_ctl.miss   = s1_miss;

   dmc_counters u_counters (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cnt_ctl),
      .hit_in  (hit_in),
      .miss_in (miss_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_addr_ff   <= s1_addr_ff;
         out_miss_ff   <= s1_miss;
         out_repl_ff   <= s1_repl;
         out_evict_ff  <= s1_repl ? old_tag : '0;
         out_hits_ff   <= hit_in;
         out_misses_ff <= miss_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_offset    = out_addr_ff[dmc_pkg::OFFSET_BITS-1:0];
   assign rsp_block_number   = out_addr_ff[dmc_pkg::ADDR_BITS-1:dmc_pkg::OFFSET_BITS];
   assign rsp_line_index     = out_addr_ff[dmc_pkg::OFFSET_BITS +: dmc_pkg::LINE_BITS];
   assign rsp_tag_value      = out_addr_ff[dmc_pkg::ADDR_BITS-1 -: dmc_pkg::TAG_BITS];
   assign rsp_is_miss        = out_miss_ff;
   assign rsp_is_replacement = out_repl_ff;
   assign rsp_evicted_tag    = out_evict_ff;
   assign rsp_hits_so_far    = out_hits_ff;
   assign rsp_misses_so_far  = out_misses_ff;

endmodule

>>> rtl/core/dmc_tag_ram.sv
// tag memory: one write port, one registered read port
module dmc_tag_ram (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [dmc_pkg::LINE_BITS-1:0]  rd_index,
   output logic [dmc_pkg::TAG_BITS-1:0]   rd_tag,
   input  logic                           wr_en,
   input  logic [dmc_pkg::LINE_BITS-1:0]  wr_index,
   input  logic [dmc_pkg::TAG_BITS-1:0]   wr_tag
);

   logic [dmc_pkg::TAG_BITS-1:0] tag_mem [dmc_pkg::NUM_LINES];
   logic [dmc_pkg::TAG_BITS-1:0] rd_tag_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_index] <= wr_tag;
      end
   end

   // read port, old data on a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff <= tag_mem[rd_index];
      end
   end

   assign rd_tag = rd_tag_ff;

endmodule

>>> rtl/core/dmc_counters.sv
// saturating hit and miss counters
module dmc_counters (
   input  logic                            clock,
   input  logic                            reset,
   input  dmc_pkg::cnt_ctl_type            ctl,
   output logic [dmc_pkg::COUNT_BITS-1:0]  hit_in,
   output logic [dmc_pkg::COUNT_BITS-1:0]  miss_in
);

   logic [dmc_pkg::COUNT_BITS-1:0] hit_total_ff;
   logic [dmc_pkg::COUNT_BITS-1:0] miss_total_ff;

   // next values, counting the access being retired
   always_comb begin
      hit_in  = hit_total_ff;
      miss_in = miss_total_ff;
      if (ctl.update) begin
         if (ctl.miss) begin
            if (miss_total_ff != '1) begin
               miss_in = miss_total_ff + 1'b1;
            end
         end else begin
            if (hit_total_ff != '1) begin
               hit_in = hit_total_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
      end else begin
         hit_total_ff  <= hit_in;
         miss_total_ff <= miss_in;
      end
   end

endmodule
